// File: rtl/fpri_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpri_pkg
// Shared types and constants of the fuzzy PD rule inference pipeline:
// payload structs, set breakpoints, ramp spans and reciprocals.
// ---------------------------------------------------------------------------
package fpri_pkg;

    localparam int Q_ONE        = 16384;
    localparam int QF           = 14;
    localparam int IN_W         = 16;
    localparam int MEM_W        = 15;
    localparam int NUM_W        = 15;
    localparam int SPAN_W       = 14;
    localparam int RCP_SHIFT    = 28;
    localparam int RCP_W        = 19;
    localparam int N_ERR_SETS   = 5;
    localparam int N_SLOPE_SETS = 3;
    localparam int N_SETS       = N_ERR_SETS + N_SLOPE_SETS;
    localparam int N_RULES      = N_ERR_SETS * N_SLOPE_SETS;
    localparam int N_LABELS     = 5;
    localparam int LABEL_W      = 3;
    localparam int RULE_TBL_W   = N_RULES * LABEL_W;
    localparam int RCP_ONE      = 1 << RCP_SHIFT;

    // Sets 0..4: error NB NS ZE PS PB; sets 5..7: slope NE ZE PO.
    // Triangles are held as trapezoids with b == c.
    localparam int SET_A [N_SETS] = '{-16384, -4915, -1638,    0,  2458,
                                      -16384, -14746,   0};
    localparam int SET_B [N_SETS] = '{-16384, -2458,     0, 1638,  4096,
                                      -16384,      0, 2785};
    localparam int SET_C [N_SETS] = '{ -4096, -1638,     0, 2458, 16384,
                                      -14746,      0, 16384};
    localparam int SET_D [N_SETS] = '{ -3277,     0,  1638, 4096, 16384,
                                           0,   2785, 16384};

    // b - a and d - c; a zero span is a shoulder
    localparam int RISE_SPAN [N_SETS] = '{0, 2457, 1638, 1638, 1638, 0, 14746, 2785};
    localparam int FALL_SPAN [N_SETS] = '{819, 1638, 1638, 1638, 0, 14746, 2785, 0};

    // floor(2^28 / span)
    localparam int RISE_RCP [N_SETS] = '{0, RCP_ONE / 2457, RCP_ONE / 1638,
                                         RCP_ONE / 1638, RCP_ONE / 1638, 0,
                                         RCP_ONE / 14746, RCP_ONE / 2785};
    localparam int FALL_RCP [N_SETS] = '{RCP_ONE / 819, RCP_ONE / 1638,
                                         RCP_ONE / 1638, RCP_ONE / 1638, 0,
                                         RCP_ONE / 14746, RCP_ONE / 2785, 0};

    typedef logic [MEM_W-1:0] mem_t;

    typedef enum logic [1:0] {
        MEM_ZERO = 2'd0,
        MEM_ONE  = 2'd1,
        MEM_RAMP = 2'd2
    } mem_mode_t;

    typedef struct packed {
        logic signed [IN_W-1:0] error_value;
        logic signed [IN_W-1:0] error_slope;
    } fpri_in_t;

    typedef struct packed {
        mem_t strength_label0;
        mem_t strength_label1;
        mem_t strength_label2;
        mem_t strength_label3;
        mem_t strength_label4;
    } fpri_out_t;

    typedef struct packed {
        mem_mode_t          mode;
        logic [NUM_W-1:0]   num;
        logic [SPAN_W-1:0]  span;
        logic [RCP_W-1:0]   rcp;
    } ramp_req_t;

    typedef struct packed {
        mem_mode_t          mode;
        logic [NUM_W-1:0]   num;
        logic [SPAN_W-1:0]  span;
        mem_t               quot;
    } ramp_est_t;

endpackage
`default_nettype wire

// File: rtl/fpri_fuzzify.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpri_fuzzify
// Stage 1: saturate both inputs and locate each on its set's trapezoid,
// giving a zero, a shoulder or a ramp with numerator, span and reciprocal.
// ---------------------------------------------------------------------------
module fpri_fuzzify (
    input  wire                                             aclk,
    input  wire                                             aresetn,
    input  wire                                             in_valid,
    output logic                                            in_ready,
    input  fpri_pkg::fpri_in_t                              in_data,
    output logic                                            out_valid,
    input  wire                                             out_ready,
    output fpri_pkg::ramp_req_t [fpri_pkg::N_SETS-1:0]      out_req
);

    localparam logic signed [16:0] POS_ONE = 17'(fpri_pkg::Q_ONE);
    localparam logic signed [16:0] NEG_ONE = -POS_ONE;

    logic                                         valid_reg;
    fpri_pkg::ramp_req_t [fpri_pkg::N_SETS-1:0]   req_reg;
    fpri_pkg::ramp_req_t [fpri_pkg::N_SETS-1:0]   req_next;
    logic signed [16:0]                           err_ext;
    logic signed [16:0]                           slope_ext;
    logic signed [16:0]                           err_c;
    logic signed [16:0]                           slope_c;

    // saturate to plus or minus one
    always_comb begin
        err_ext   = {in_data.error_value[fpri_pkg::IN_W-1], in_data.error_value};
        slope_ext = {in_data.error_slope[fpri_pkg::IN_W-1], in_data.error_slope};
        if (err_ext > POS_ONE) begin
            err_c = POS_ONE;
        end else if (err_ext < NEG_ONE) begin
            err_c = NEG_ONE;
        end else begin
            err_c = err_ext;
        end
        if (slope_ext > POS_ONE) begin
            slope_c = POS_ONE;
        end else if (slope_ext < NEG_ONE) begin
            slope_c = NEG_ONE;
        end else begin
            slope_c = slope_ext;
        end
    end

    always_comb begin
        logic signed [16:0] xv;
        logic signed [16:0] av;
        logic signed [16:0] bv;
        logic signed [16:0] cv;
        logic signed [16:0] dv;
        logic signed [16:0] diff;
        for (int k = 0; k < fpri_pkg::N_SETS; k++) begin
            xv = (k < fpri_pkg::N_ERR_SETS) ? err_c : slope_c;
            av = 17'(fpri_pkg::SET_A[k]);
            bv = 17'(fpri_pkg::SET_B[k]);
            cv = 17'(fpri_pkg::SET_C[k]);
            dv = 17'(fpri_pkg::SET_D[k]);
            diff = '0;
            req_next[k].mode = fpri_pkg::MEM_ZERO;
            req_next[k].num  = '0;
            req_next[k].span = '0;
            req_next[k].rcp  = '0;
            if (xv < av) begin
                req_next[k].mode = fpri_pkg::MEM_ZERO;
            end else if (xv <= bv) begin
                diff = xv - av;
                if (fpri_pkg::RISE_SPAN[k] == 0) begin
                    req_next[k].mode = fpri_pkg::MEM_ONE;
                end else begin
                    req_next[k].mode = fpri_pkg::MEM_RAMP;
                    req_next[k].num  = diff[fpri_pkg::NUM_W-1:0];
                    req_next[k].span = fpri_pkg::SPAN_W'(fpri_pkg::RISE_SPAN[k]);
                    req_next[k].rcp  = fpri_pkg::RCP_W'(fpri_pkg::RISE_RCP[k]);
                end
            end else if (xv < cv) begin
                req_next[k].mode = fpri_pkg::MEM_ONE;
            end else if (xv <= dv) begin
                diff = dv - xv;
                if (fpri_pkg::FALL_SPAN[k] == 0) begin
                    req_next[k].mode = fpri_pkg::MEM_ONE;
                end else begin
                    req_next[k].mode = fpri_pkg::MEM_RAMP;
                    req_next[k].num  = diff[fpri_pkg::NUM_W-1:0];
                    req_next[k].span = fpri_pkg::SPAN_W'(fpri_pkg::FALL_SPAN[k]);
                    req_next[k].rcp  = fpri_pkg::RCP_W'(fpri_pkg::FALL_RCP[k]);
                end
            end else begin
                req_next[k].mode = fpri_pkg::MEM_ZERO;
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_req   = req_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            req_reg <= req_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/fpri_scale.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpri_scale
// Stages 2 and 3: num * 16384 / span for every set. Stage 2 multiplies by
// the reciprocal; stage 3 multiplies back and corrects the one-off low
// estimate, then resolves zero and shoulder memberships.
// ---------------------------------------------------------------------------
module fpri_scale (
    input  wire                                             aclk,
    input  wire                                             aresetn,
    input  wire                                             in_valid,
    output logic                                            in_ready,
    input  fpri_pkg::ramp_req_t [fpri_pkg::N_SETS-1:0]      in_req,
    output logic                                            out_valid,
    input  wire                                             out_ready,
    output fpri_pkg::mem_t [fpri_pkg::N_SETS-1:0]           out_mem
);

    localparam int MUL_W  = fpri_pkg::NUM_W + fpri_pkg::RCP_W;
    localparam int PROD_W = fpri_pkg::MEM_W + fpri_pkg::SPAN_W;

    logic                                          est_valid_reg;
    logic                                          mem_valid_reg;
    logic                                          est_ready;
    logic                                          mem_ready;
    fpri_pkg::ramp_est_t [fpri_pkg::N_SETS-1:0]    est_reg;
    fpri_pkg::ramp_est_t [fpri_pkg::N_SETS-1:0]    est_next;
    fpri_pkg::mem_t [fpri_pkg::N_SETS-1:0]         mem_reg;
    fpri_pkg::mem_t [fpri_pkg::N_SETS-1:0]         mem_next;

    // quotient estimate: (num * rcp) >> 14, never above the true quotient
    always_comb begin
        logic [MUL_W-1:0] prod;
        for (int k = 0; k < fpri_pkg::N_SETS; k++) begin
            prod = MUL_W'(in_req[k].num) * MUL_W'(in_req[k].rcp);
            est_next[k].mode = in_req[k].mode;
            est_next[k].num  = in_req[k].num;
            est_next[k].span = in_req[k].span;
            est_next[k].quot = prod[fpri_pkg::QF +: fpri_pkg::MEM_W];
        end
    end

    // back-multiply and bump the estimate when a whole span is left over
    always_comb begin
        logic [PROD_W-1:0] back;
        logic [PROD_W-1:0] full;
        logic [PROD_W-1:0] rem;
        for (int k = 0; k < fpri_pkg::N_SETS; k++) begin
            back = PROD_W'(est_reg[k].quot) * PROD_W'(est_reg[k].span);
            full = PROD_W'({est_reg[k].num, {fpri_pkg::QF{1'b0}}});
            rem  = full - back;
            case (est_reg[k].mode)
                fpri_pkg::MEM_ONE: begin
                    mem_next[k] = fpri_pkg::MEM_W'(fpri_pkg::Q_ONE);
                end
                fpri_pkg::MEM_RAMP: begin
                    if (rem >= PROD_W'(est_reg[k].span)) begin
                        mem_next[k] = est_reg[k].quot + fpri_pkg::MEM_W'(1);
                    end else begin
                        mem_next[k] = est_reg[k].quot;
                    end
                end
                default: begin
                    mem_next[k] = '0;
                end
            endcase
        end
    end

    assign mem_ready = !mem_valid_reg || out_ready;
    assign est_ready = !est_valid_reg || mem_ready;
    assign in_ready  = est_ready;
    assign out_valid = mem_valid_reg;
    assign out_mem   = mem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_valid_reg <= 1'b0;
            mem_valid_reg <= 1'b0;
        end else begin
            if (est_ready) begin
                est_valid_reg <= in_valid;
            end
            if (mem_ready) begin
                mem_valid_reg <= est_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (est_ready && in_valid) begin
            est_reg <= est_next;
        end
        if (mem_ready && est_valid_reg) begin
            mem_reg <= mem_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/fpri_rule_eval.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fpri_rule_eval
// Stages 4 and 5: rule strength as the min of two memberships, then per
// output label the max of the strengths of the rules mapped to it.
// Stage 5 is the output register.
// ---------------------------------------------------------------------------
module fpri_rule_eval (
    input  wire                                             aclk,
    input  wire                                             aresetn,
    input  wire [fpri_pkg::RULE_TBL_W-1:0]                  rule_table,
    input  wire                                             in_valid,
    output logic                                            in_ready,
    input  fpri_pkg::mem_t [fpri_pkg::N_SETS-1:0]           in_mem,
    output logic                                            out_valid,
    input  wire                                             out_ready,
    output fpri_pkg::fpri_out_t                             out_data
);

    localparam int LEAVES = 16;
    localparam int NODES  = 2 * LEAVES - 1;

    logic                                          str_valid_reg;
    logic                                          out_valid_reg;
    logic                                          str_ready;
    logic                                          out_ready_int;
    fpri_pkg::mem_t [fpri_pkg::N_RULES-1:0]        str_reg;
    fpri_pkg::mem_t [fpri_pkg::N_RULES-1:0]        str_next;
    fpri_pkg::mem_t [fpri_pkg::N_LABELS-1:0]       best;
    fpri_pkg::fpri_out_t                           out_reg;
    fpri_pkg::fpri_out_t                           out_next;

    // rule r = error_set * 3 + slope_set
    always_comb begin
        fpri_pkg::mem_t me;
        fpri_pkg::mem_t md;
        for (int i = 0; i < fpri_pkg::N_ERR_SETS; i++) begin
            for (int j = 0; j < fpri_pkg::N_SLOPE_SETS; j++) begin
                me = in_mem[i];
                md = in_mem[fpri_pkg::N_ERR_SETS + j];
                str_next[i * fpri_pkg::N_SLOPE_SETS + j] = (me < md) ? me : md;
            end
        end
    end

    // per label: mask rules of other labels, then a max tree over 16 leaves
    always_comb begin
        fpri_pkg::mem_t node [NODES];
        for (int lab = 0; lab < fpri_pkg::N_LABELS; lab++) begin
            for (int r = 0; r < LEAVES; r++) begin
                node[LEAVES - 1 + r] = '0;
                if (r < fpri_pkg::N_RULES) begin
                    if (rule_table[fpri_pkg::LABEL_W * r +: fpri_pkg::LABEL_W] ==
                        fpri_pkg::LABEL_W'(lab)) begin
                        node[LEAVES - 1 + r] = str_reg[r];
                    end
                end
            end
            for (int n = LEAVES - 2; n >= 0; n--) begin
                node[n] = (node[2 * n + 1] > node[2 * n + 2]) ? node[2 * n + 1]
                                                              : node[2 * n + 2];
            end
            best[lab] = node[0];
        end
    end

    always_comb begin
        out_next.strength_label0 = best[0];
        out_next.strength_label1 = best[1];
        out_next.strength_label2 = best[2];
        out_next.strength_label3 = best[3];
        out_next.strength_label4 = best[4];
    end

    assign out_ready_int = !out_valid_reg || out_ready;
    assign str_ready     = !str_valid_reg || out_ready_int;
    assign in_ready      = str_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            str_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (str_ready) begin
                str_valid_reg <= in_valid;
            end
            if (out_ready_int) begin
                out_valid_reg <= str_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (str_ready && in_valid) begin
            str_reg <= str_next;
        end
        if (out_ready_int && str_valid_reg) begin
            out_reg <= out_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/fuzzy_pd_rule_inference.sv
`default_nettype none
// ---------------------------------------------------------------------------
// fuzzy_pd_rule_inference
// Min-max fuzzy rule inference for a PD controller: fuzzify error and
// error slope, fire 15 rules, report max strength per output label.
// ---------------------------------------------------------------------------
// The block accepts one request per cycle unless a stall on m_ready has
// filled the pipe, and returns results in order. The five register stages are: input
// saturation and set location, reciprocal multiply, back-multiply with
// quotient correction, rule minimum, and per-label maximum (the output
// register). Each stage holds its own valid bit, so a stall on m_ready
// backs up stage by stage and s_ready drops only when all five are full.
// rule_table is written through cfg_wr_en / cfg_wr_data; write it only
// while no request is in flight.
module fuzzy_pd_rule_inference (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_wr_en,
    input  wire [fpri_pkg::RULE_TBL_W-1:0]      cfg_wr_data,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  fpri_pkg::fpri_in_t                  s_payload,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output fpri_pkg::fpri_out_t                 m_payload
);

    logic [fpri_pkg::RULE_TBL_W-1:0]               rule_table_reg;
    logic                                          fz_valid;
    logic                                          fz_ready;
    fpri_pkg::ramp_req_t [fpri_pkg::N_SETS-1:0]    fz_req;
    logic                                          sc_valid;
    logic                                          sc_ready;
    fpri_pkg::mem_t [fpri_pkg::N_SETS-1:0]         sc_mem;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_table_reg <= '0;
        end else if (cfg_wr_en) begin
            rule_table_reg <= cfg_wr_data;
        end
    end

    fpri_fuzzify u_fuzzify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_payload),
        .out_valid (fz_valid),
        .out_ready (fz_ready),
        .out_req   (fz_req)
    );

    fpri_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fz_valid),
        .in_ready  (fz_ready),
        .in_req    (fz_req),
        .out_valid (sc_valid),
        .out_ready (sc_ready),
        .out_mem   (sc_mem)
    );

    fpri_rule_eval u_rule_eval (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rule_table (rule_table_reg),
        .in_valid   (sc_valid),
        .in_ready   (sc_ready),
        .in_mem     (sc_mem),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (m_payload)
    );

    // strengths never exceed 1.0
    a_strength_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.strength_label0 <= 15'(fpri_pkg::Q_ONE) &&
                     m_payload.strength_label1 <= 15'(fpri_pkg::Q_ONE) &&
                     m_payload.strength_label2 <= 15'(fpri_pkg::Q_ONE) &&
                     m_payload.strength_label3 <= 15'(fpri_pkg::Q_ONE) &&
                     m_payload.strength_label4 <= 15'(fpri_pkg::Q_ONE)))
        else $error("strength above 1.0 on output");

    // input backpressure only when the whole pipe is full and the output stalls
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && fz_valid && sc_valid))
        else $error("input stalled while pipeline has room");

    // a filled stage-3 result waiting on stage 4 implies the output is stalled
    a_mid_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (sc_valid && !sc_ready) |-> (m_valid && !m_ready))
        else $error("stage 3 stalled without output backpressure");

endmodule
`default_nettype wire
